/* hw/rtl/ean8_validate_and_encode_top_macros.svh */
// ----------------------------------------------------------------------------
// EAN-8 encoder assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef EAN8_VALIDATE_AND_ENCODE_TOP_MACROS_SVH
`define EAN8_VALIDATE_AND_ENCODE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define E8VE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define E8VE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/e8ve_pkg.sv */
// ----------------------------------------------------------------------------
// EAN-8 encoder package
// Status codes, segment constants, queue entry type and the L-code table.
// ----------------------------------------------------------------------------
`default_nettype none

package e8ve_pkg;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_LEN   = 2'd1;
    localparam t_status ST_CHAR  = 2'd2;
    localparam t_status ST_CHECK = 2'd3;

    localparam logic [3:0] CODE_LEN   = 4'd8;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;

    // floor(x / 10) == (x * 205) >> 11 for x below 1029
    localparam logic [15:0] MOD10_RECIP = 16'd205;

    localparam logic [6:0] GUARD_EDGE   = 7'h05;
    localparam logic [6:0] GUARD_CENTER = 7'h0A;
    localparam logic [6:0] R_CODE_MASK  = 7'h7F;

    localparam logic [2:0] WIDTH_EDGE   = 3'd3;
    localparam logic [2:0] WIDTH_CENTER = 3'd5;
    localparam logic [2:0] WIDTH_DIGIT  = 3'd7;

    // segment sequence positions
    localparam logic [3:0] SEG_START  = 4'd0;
    localparam logic [3:0] SEG_CENTER = 4'd5;
    localparam logic [3:0] SEG_END    = 4'd10;

    typedef struct packed {
        t_status          status;
        logic [3:0]       check;
        logic [7:0][3:0]  digits;
    } t_entry;

    function automatic logic [6:0] l_code(input logic [3:0] digit);
        logic [6:0] code;
        unique case (digit)
            4'd0:    code = 7'h0D;
            4'd1:    code = 7'h19;
            4'd2:    code = 7'h13;
            4'd3:    code = 7'h3D;
            4'd4:    code = 7'h23;
            4'd5:    code = 7'h31;
            4'd6:    code = 7'h2F;
            4'd7:    code = 7'h3B;
            4'd8:    code = 7'h37;
            4'd9:    code = 7'h0B;
            default: code = 7'h00;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/e8ve_if.sv */
// ----------------------------------------------------------------------------
// EAN-8 encoder channels
// Valid/ready interfaces for the code request and the segment response.
// ----------------------------------------------------------------------------
`default_nettype none

interface e8ve_req_if;
    logic       valid;
    logic       ready;
    logic [3:0] code_length;
    logic [7:0] char_0;
    logic [7:0] char_1;
    logic [7:0] char_2;
    logic [7:0] char_3;
    logic [7:0] char_4;
    logic [7:0] char_5;
    logic [7:0] char_6;
    logic [7:0] char_7;

    modport source (
        output valid, code_length, char_0, char_1, char_2, char_3,
               char_4, char_5, char_6, char_7,
        input  ready
    );
    modport sink (
        input  valid, code_length, char_0, char_1, char_2, char_3,
               char_4, char_5, char_6, char_7,
        output ready
    );
endinterface

interface e8ve_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [6:0] segment_bits;
    logic [2:0] segment_width;
    logic [3:0] computed_check;
    logic       last;

    modport source (
        output valid, status, segment_bits, segment_width, computed_check, last,
        input  ready
    );
    modport sink (
        input  valid, status, segment_bits, segment_width, computed_check, last,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/e8ve_front.sv */
// ----------------------------------------------------------------------------
// EAN-8 encoder front end
// Registers a request, then classifies it and pushes one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module e8ve_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    e8ve_req_if.sink          i_req,
    output logic              o_push_valid,
    input  wire               i_push_ready,
    output e8ve_pkg::t_entry  o_push_data
);

    logic [7:0][7:0] w_chars;
    logic [7:0][3:0] w_digits;
    logic            w_len_bad;
    logic            w_chr_bad;
    logic [5:0]      w_even;
    logic [4:0]      w_odd;
    logic [7:0]      w_sum;
    logic            w_accept;

    logic            r_s1_valid;
    logic            r_s1_len_bad;
    logic            r_s1_chr_bad;
    logic [7:0]      r_s1_sum;
    logic [7:0][3:0] r_s1_digits;

    logic [15:0]     w_prod;
    logic [4:0]      w_quot;
    logic [7:0]      w_rem;
    logic [3:0]      w_check;

    assign w_chars = {i_req.char_7, i_req.char_6, i_req.char_5, i_req.char_4,
                      i_req.char_3, i_req.char_2, i_req.char_1, i_req.char_0};

    always_comb begin
        w_chr_bad = 1'b0;
        for (int k = 0; k < 8; k++) begin
            w_digits[k] = w_chars[k][3:0];
            if (w_chars[k] < e8ve_pkg::ASCII_ZERO || w_chars[k] > e8ve_pkg::ASCII_NINE) begin
                w_chr_bad = 1'b1;
            end
        end
    end

    assign w_len_bad = (i_req.code_length != e8ve_pkg::CODE_LEN);
    assign w_even = 6'(w_digits[0]) + 6'(w_digits[2]) + 6'(w_digits[4]) + 6'(w_digits[6]);
    assign w_odd  = 5'(w_digits[1]) + 5'(w_digits[3]) + 5'(w_digits[5]);
    assign w_sum  = 8'({w_even, 1'b0}) + 8'(w_even) + 8'(w_odd);

    assign i_req.ready  = !r_s1_valid || i_push_ready;
    assign w_accept     = i_req.valid && i_req.ready;
    assign o_push_valid = r_s1_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_len_bad <= w_len_bad;
            r_s1_chr_bad <= w_chr_bad;
            r_s1_sum     <= w_sum;
            r_s1_digits  <= w_digits;
        end
    end

    // sum mod 10 by reciprocal multiply, then the check digit
    assign w_prod  = 16'(r_s1_sum) * e8ve_pkg::MOD10_RECIP;
    assign w_quot  = w_prod[15:11];
    assign w_rem   = r_s1_sum - 8'({w_quot, 3'b000}) - 8'({w_quot, 1'b0});
    assign w_check = (w_rem[3:0] == 4'd0) ? 4'd0 : 4'(4'd10 - w_rem[3:0]);

    always_comb begin
        o_push_data.digits = r_s1_digits;
        priority if (r_s1_len_bad) begin
            o_push_data.status = e8ve_pkg::ST_LEN;
            o_push_data.check  = 4'd0;
        end else if (r_s1_chr_bad) begin
            o_push_data.status = e8ve_pkg::ST_CHAR;
            o_push_data.check  = 4'd0;
        end else if (w_check != r_s1_digits[7]) begin
            o_push_data.status = e8ve_pkg::ST_CHECK;
            o_push_data.check  = w_check;
        end else begin
            o_push_data.status = e8ve_pkg::ST_OK;
            o_push_data.check  = w_check;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/e8ve_fifo.sv */
// ----------------------------------------------------------------------------
// EAN-8 encoder queue
// Small show-ahead register queue between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module e8ve_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire  [WIDTH-1:0] i_push_data,
    output logic             o_push_ready,
    input  wire              i_pop,
    output logic             o_head_valid,
    output logic [WIDTH-1:0] o_head_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head_data  = r_mem[r_rd_ptr];
    assign w_push       = i_push && o_push_ready;
    assign w_pop        = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/e8ve_back.sv */
// ----------------------------------------------------------------------------
// EAN-8 encoder back end
// Walks the queue head through its segments into the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module e8ve_back (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_head_valid,
    input  wire e8ve_pkg::t_entry  i_head_data,
    output logic                   o_pop,
    e8ve_rsp_if.source             o_rsp
);

    logic [3:0] r_idx;
    logic [3:0] n_idx;
    logic       r_out_valid;
    logic [1:0] r_status;
    logic [6:0] r_bits;
    logic [2:0] r_width;
    logic [3:0] r_check;
    logic       r_last;

    logic       w_load;
    logic [6:0] n_bits;
    logic [2:0] n_width;
    logic       n_last;
    logic [2:0] w_left_sel;
    logic [2:0] w_right_sel;

    assign w_load      = i_head_valid && (!r_out_valid || o_rsp.ready);
    assign w_left_sel  = 3'(r_idx - 4'd1);
    assign w_right_sel = 3'(r_idx - 4'd2);

    always_comb begin
        n_bits  = 7'd0;
        n_width = 3'd0;
        n_last  = 1'b1;
        n_idx   = r_idx;
        if (i_head_data.status == e8ve_pkg::ST_OK) begin
            n_last = 1'b0;
            n_idx  = r_idx + 4'd1;
            priority if (r_idx == e8ve_pkg::SEG_START) begin
                n_bits  = e8ve_pkg::GUARD_EDGE;
                n_width = e8ve_pkg::WIDTH_EDGE;
            end else if (r_idx < e8ve_pkg::SEG_CENTER) begin
                n_bits  = e8ve_pkg::l_code(i_head_data.digits[w_left_sel]);
                n_width = e8ve_pkg::WIDTH_DIGIT;
            end else if (r_idx == e8ve_pkg::SEG_CENTER) begin
                n_bits  = e8ve_pkg::GUARD_CENTER;
                n_width = e8ve_pkg::WIDTH_CENTER;
            end else if (r_idx < e8ve_pkg::SEG_END) begin
                n_bits  = e8ve_pkg::l_code(i_head_data.digits[w_right_sel])
                          ^ e8ve_pkg::R_CODE_MASK;
                n_width = e8ve_pkg::WIDTH_DIGIT;
            end else begin
                n_bits  = e8ve_pkg::GUARD_EDGE;
                n_width = e8ve_pkg::WIDTH_EDGE;
                n_last  = 1'b1;
                n_idx   = e8ve_pkg::SEG_START;
            end
        end
    end

    assign o_pop = w_load && n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= e8ve_pkg::SEG_START;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_idx       <= n_idx;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status <= i_head_data.status;
            r_bits   <= n_bits;
            r_width  <= n_width;
            r_check  <= i_head_data.check;
            r_last   <= n_last;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_status;
    assign o_rsp.segment_bits   = r_bits;
    assign o_rsp.segment_width  = r_width;
    assign o_rsp.computed_check = r_check;
    assign o_rsp.last           = r_last;

endmodule

`default_nettype wire

/* hw/rtl/ean8_validate_and_encode_top.sv */
// ----------------------------------------------------------------------------
// EAN-8 validate and encode, top level
// Checks an 8-character EAN-8 code and emits its bar segments.
// ----------------------------------------------------------------------------
//  channel  | dir | request contents                         | per code
//  ---------+-----+------------------------------------------+----------------
//  i_req    | in  | code_length, char_0 .. char_7            | 1
//  o_rsp    | out | status, segment_bits, segment_width,     | 11 ok, 1 error
//           |     | computed_check, last                     |
//
//  Valid code: 11 response segments (start, 4 L digits, center, 4 R digits,
//  end); a rejected code: 1 segment. The back-end segment sequencer emits them.
//  Request path to the first response: front register, queue, output register.
//  Reset: synchronous, active low; clears valids, queue pointers, counter.
//  Stalls: the queue lets the front end take requests while o_rsp is held, until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module ean8_validate_and_encode_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    e8ve_req_if.sink    i_req,
    e8ve_rsp_if.source  o_rsp
);

    // front end -> queue
    logic              w_push_valid;
    logic              w_push_ready;
    e8ve_pkg::t_entry  w_push_data;

    // queue -> back end
    logic              w_head_valid;
    e8ve_pkg::t_entry  w_head_data;
    logic              w_pop;

    // Front end: registers the request, validates length and characters,
    // computes the weighted sum and check digit.
    e8ve_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data)
    );

    // Classified codes wait here while the back end is busy.
    e8ve_fifo #(
        .WIDTH ($bits(e8ve_pkg::t_entry)),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push_valid),
        .i_push_data  (w_push_data),
        .o_push_ready (w_push_ready),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head_data  (w_head_data)
    );

    // Back end: one segment per cycle from the queue head when o_rsp is not
    // stalled; the entry is popped with its final segment.
    e8ve_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head_data  (w_head_data),
        .o_pop        (w_pop),
        .o_rsp        (o_rsp)
    );

endmodule

`default_nettype wire

/* hw/rtl/e8ve_chk.sv */
// ----------------------------------------------------------------------------
// EAN-8 encoder checker
// Port-level assertions on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ean8_validate_and_encode_top_macros.svh"

module e8ve_chk (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_valid,
    input wire       i_ready,
    input wire [1:0] i_status,
    input wire [6:0] i_bits,
    input wire [2:0] i_width,
    input wire [3:0] i_check,
    input wire       i_last
);

    `E8VE_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_status) && $stable(i_bits) && $stable(i_width) && $stable(i_check) && $stable(i_last), "response changed while stalled")
    `E8VE_ASSERT_SAME(a_err_single, i_clk, i_rst_n, i_valid && i_status != e8ve_pkg::ST_OK, i_last && i_width == 3'd0 && i_bits == 7'd0, "error response not a lone empty segment")
    `E8VE_ASSERT_SAME(a_ok_width, i_clk, i_rst_n, i_valid && i_status == e8ve_pkg::ST_OK, i_width == e8ve_pkg::WIDTH_EDGE || i_width == e8ve_pkg::WIDTH_CENTER || i_width == e8ve_pkg::WIDTH_DIGIT, "bad segment width")
    `E8VE_ASSERT_SAME(a_ok_end, i_clk, i_rst_n, i_valid && i_status == e8ve_pkg::ST_OK && i_last, i_bits == e8ve_pkg::GUARD_EDGE && i_width == e8ve_pkg::WIDTH_EDGE, "final segment is not the end guard")

endmodule

bind ean8_validate_and_encode_top e8ve_chk u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_rsp.valid),
    .i_ready  (o_rsp.ready),
    .i_status (o_rsp.status),
    .i_bits   (o_rsp.segment_bits),
    .i_width  (o_rsp.segment_width),
    .i_check  (o_rsp.computed_check),
    .i_last   (o_rsp.last)
);

`default_nettype wire
